[hw/rtl/qte_pkg.sv]
// qte_pkg: shared widths, types and the arctangent table of the
// quaternion to euler angles pipeline; no dependencies
package qte_pkg;

    // number of micro-rotations, capped at the table length
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int NUM_ROT = (CORDIC_ITERATIONS < ATAN_ENTRIES) ?
                             CORDIC_ITERATIONS : ATAN_ENTRIES;

    // operand widths
    localparam int Q_W    = 16;  // input component
    localparam int T_W    = 34;  // atan2 operand at scale 2^28
    localparam int P_W    = 30;  // clamped pitch sine, holds +-2^28
    localparam int N_W    = 58;  // radicand and root work registers
    localparam int SQ_STEPS = 29; // root bits produced one per stage
    localparam int X_W    = 36;  // cordic vector width
    localparam int Z_W    = 34;  // cordic angle at scale 2^30
    localparam int A_W    = 16;  // output angle

    localparam logic signed [T_W-1:0] ONE_Q28 = T_W'(64'sd268435456);
    localparam logic signed [A_W-1:0] LIMIT_FULL = A_W'(25736);
    localparam logic signed [A_W-1:0] LIMIT_HALF = A_W'(12868);

    // floor(atan(2^-i) * 2^30)
    localparam logic signed [Z_W-1:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
        34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
        34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
        34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
        34'sd1023,      34'sd511,       34'sd255,       34'sd127
    };

    // operands carried past the square root
    typedef struct packed {
        logic signed [T_W-1:0] t0;
        logic signed [T_W-1:0] t1;
        logic signed [P_W-1:0] t2;
        logic signed [T_W-1:0] t3;
        logic signed [T_W-1:0] t4;
    } t_side;

endpackage

[hw/rtl/qte_prod.sv]
// qte_prod: products, atan2 operands and the pitch radicand in three stages
// depends on qte_pkg
module qte_prod (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [qte_pkg::Q_W-1:0] i_x,
    input  logic signed [qte_pkg::Q_W-1:0] i_y,
    input  logic signed [qte_pkg::Q_W-1:0] i_z,
    input  logic signed [qte_pkg::Q_W-1:0] i_w,
    output logic                         o_valid,
    output logic [qte_pkg::N_W-1:0]      o_n,
    output qte_pkg::t_side               o_side
);
    import qte_pkg::*;

    logic [2:0] r_v;
    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_side r_side2, r_side3;
    logic [N_W-1:0] r_n;
    logic signed [T_W-1:0] n_t2;
    logic signed [P_W-1:0] n_t2c;
    logic signed [2*P_W-1:0] n_sq;

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // clamp pitch sine to +-1
    always_comb begin
        n_t2 = T_W'(2 * (34'(r_wy) - 34'(r_zx)));
        if (n_t2 > ONE_Q28) begin
            n_t2c = P_W'(ONE_Q28);
        end else if (n_t2 < -ONE_Q28) begin
            n_t2c = P_W'(-ONE_Q28);
        end else begin
            n_t2c = P_W'(n_t2);
        end
        n_sq = r_side2.t2 * r_side2.t2;
    end

    // stage 1 products, stage 2 sums, stage 3 square
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
            r_side2.t0 <= T_W'(2 * (34'(r_wx) + 34'(r_yz)));
            r_side2.t1 <= ONE_Q28 - T_W'(2 * (34'(r_xx) + 34'(r_yy)));
            r_side2.t2 <= n_t2c;
            r_side2.t3 <= T_W'(2 * (34'(r_wz) + 34'(r_xy)));
            r_side2.t4 <= ONE_Q28 - T_W'(2 * (34'(r_yy) + 34'(r_zz)));
            r_side3 <= r_side2;
            r_n <= (N_W'(1) << 56) - N_W'(n_sq);
        end
    end

    assign o_valid = r_v[2];
    assign o_n     = r_n;
    assign o_side  = r_side3;
endmodule

[hw/rtl/qte_isqrt.sv]
// qte_isqrt: pipelined integer square root, one root bit per stage
// depends on qte_pkg
module qte_isqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [qte_pkg::N_W-1:0] i_n,
    input  qte_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [qte_pkg::P_W-1:0] o_root,
    output qte_pkg::t_side          o_side
);
    import qte_pkg::*;

    logic [N_W-1:0] w_op  [0:SQ_STEPS];
    logic [N_W-1:0] w_res [0:SQ_STEPS];
    t_side          w_sd  [0:SQ_STEPS];
    logic           w_v   [0:SQ_STEPS];

    assign w_op[0]  = i_n;
    assign w_res[0] = '0;
    assign w_sd[0]  = i_side;
    assign w_v[0]   = i_valid;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [N_W-1:0] BIT = N_W'(1) << (56 - 2*k);
        logic [N_W-1:0] r_op, r_res;
        t_side r_sd;
        logic r_v;
        logic [N_W-1:0] n_trial;

        assign n_trial = w_res[k] + BIT;

        // restoring step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_op[k] >= n_trial) begin
                    r_op  <= w_op[k] - n_trial;
                    r_res <= (w_res[k] >> 1) + BIT;
                end else begin
                    r_op  <= w_op[k];
                    r_res <= w_res[k] >> 1;
                end
                r_sd <= w_sd[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        assign w_op[k+1]  = r_op;
        assign w_res[k+1] = r_res;
        assign w_sd[k+1]  = r_sd;
        assign w_v[k+1]   = r_v;
    end

    assign o_valid = w_v[SQ_STEPS];
    assign o_root  = w_res[SQ_STEPS][P_W-1:0];
    assign o_side  = w_sd[SQ_STEPS];
endmodule

[hw/rtl/qte_cordic.sv]
// qte_cordic: pipelined vectoring cordic atan2 with rounding to Q3.13
// depends on qte_pkg
module qte_cordic (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic signed [qte_pkg::T_W-1:0] i_y,
    input  logic signed [qte_pkg::T_W-1:0] i_x,
    input  logic signed [qte_pkg::A_W-1:0] i_limit,
    output logic                           o_valid,
    output logic signed [qte_pkg::A_W-1:0] o_angle
);
    import qte_pkg::*;

    logic signed [X_W-1:0] w_x [0:NUM_ROT];
    logic signed [X_W-1:0] w_y [0:NUM_ROT];
    logic signed [Z_W-1:0] w_z [0:NUM_ROT];
    logic                  w_zero [0:NUM_ROT];
    logic                  w_v [0:NUM_ROT];

    logic signed [X_W-1:0] r_x0, r_y0, n_xe, n_ye;
    logic signed [Z_W-1:0] r_z0;
    logic                  r_zero0, r_v0;

    assign n_xe = X_W'(i_x);
    assign n_ye = X_W'(i_y);

    // quarter turn into the right half-plane
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero0 <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x0 <= n_ye;
                    r_y0 <= -n_xe;
                    r_z0 <= 2 * ATAN_TAB[0];
                end else begin
                    r_x0 <= -n_ye;
                    r_y0 <= n_xe;
                    r_z0 <= -2 * ATAN_TAB[0];
                end
            end else begin
                r_x0 <= n_xe;
                r_y0 <= n_ye;
                r_z0 <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_en) begin
            r_v0 <= i_valid;
        end
    end

    assign w_x[0] = r_x0;
    assign w_y[0] = r_y0;
    assign w_z[0] = r_z0;
    assign w_zero[0] = r_zero0;
    assign w_v[0] = r_v0;

    // one micro-rotation per stage
    for (genvar k = 0; k < NUM_ROT; k++) begin : g_rot
        logic signed [X_W-1:0] r_x, r_y;
        logic signed [Z_W-1:0] r_z;
        logic r_zero, r_v;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[k][X_W-1]) begin
                    r_x <= w_x[k] + (w_y[k] >>> k);
                    r_y <= w_y[k] - (w_x[k] >>> k);
                    r_z <= w_z[k] + ATAN_TAB[k];
                end else begin
                    r_x <= w_x[k] - (w_y[k] >>> k);
                    r_y <= w_y[k] + (w_x[k] >>> k);
                    r_z <= w_z[k] - ATAN_TAB[k];
                end
                r_zero <= w_zero[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= w_v[k];
            end
        end

        assign w_x[k+1] = r_x;
        assign w_y[k+1] = r_y;
        assign w_z[k+1] = r_z;
        assign w_zero[k+1] = r_zero;
        assign w_v[k+1] = r_v;
    end

    // round halves away from zero, saturate
    logic [Z_W-1:0] n_mag;
    logic [16:0]    n_r;
    logic signed [A_W-1:0] n_sat, r_angle;
    logic r_v;

    always_comb begin
        n_mag = w_z[NUM_ROT][Z_W-1] ? Z_W'(-w_z[NUM_ROT]) : Z_W'(w_z[NUM_ROT]);
        n_r   = 17'((n_mag + Z_W'(65536)) >> 17);
        if (n_r > 17'(i_limit)) begin
            n_sat = i_limit;
        end else begin
            n_sat = A_W'(n_r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (w_zero[NUM_ROT]) begin
                r_angle <= '0;
            end else begin
                r_angle <= w_z[NUM_ROT][Z_W-1] ? -n_sat : n_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= w_v[NUM_ROT];
        end
    end

    assign o_valid = r_v;
    assign o_angle = r_angle;
endmodule

[hw/rtl/quaternion_to_euler_angles.sv]
// quaternion_to_euler_angles: top level, quaternion in, roll/pitch/yaw out
// depends on qte_pkg, qte_prod, qte_isqrt, qte_cordic
//
// Input stream: one quaternion per transfer on s_axis (x, y, z, w, each
// signed Q2.14). Output stream: roll, pitch and yaw in radians, signed
// Q3.13 (pitch as a 15-bit Q2.13 field), one transfer per input transfer, in order.
// The datapath is one pipeline: three stages of products and sums, 29
// square-root stages (one root bit each), one quarter-turn stage, 16
// cordic stages and one rounding stage. One quaternion is taken every
// cycle when nothing stalls.
// Reset (i_rst_n low at a clock edge) clears all valid bits; the data
// registers are not reset.
// When the receiver holds m_axis_tready low while a result is shown, the
// whole pipeline freezes and s_axis_tready drops; nothing is lost or
// repeated. While the output register is empty the pipeline keeps moving.
module quaternion_to_euler_angles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // quat_x, quat_y, quat_z, quat_w
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata   // roll_angle, pitch_angle, yaw_angle, pad
);
    import qte_pkg::*;

    logic en;
    logic p_valid, s_valid, roll_v, pitch_v, yaw_v;
    logic [N_W-1:0] p_n;
    t_side p_side, s_side;
    logic [P_W-1:0] s_root;
    logic signed [A_W-1:0] roll, pitch, yaw;

    // advance unless a shown result is stalled
    assign en = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    qte_prod u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(s_axis_tvalid),
        .i_x(s_axis_tdata[15:0]), .i_y(s_axis_tdata[31:16]),
        .i_z(s_axis_tdata[47:32]), .i_w(s_axis_tdata[63:48]),
        .o_valid(p_valid), .o_n(p_n), .o_side(p_side)
    );

    qte_isqrt u_isqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en),
        .i_valid(p_valid), .i_n(p_n), .i_side(p_side),
        .o_valid(s_valid), .o_root(s_root), .o_side(s_side)
    );

    qte_cordic u_roll (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_valid),
        .i_y(s_side.t0), .i_x(s_side.t1), .i_limit(LIMIT_FULL),
        .o_valid(roll_v), .o_angle(roll)
    );

    qte_cordic u_pitch (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_valid),
        .i_y(T_W'(s_side.t2)), .i_x(signed'(T_W'(s_root))), .i_limit(LIMIT_HALF),
        .o_valid(pitch_v), .o_angle(pitch)
    );

    qte_cordic u_yaw (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(s_valid),
        .i_y(s_side.t3), .i_x(s_side.t4), .i_limit(LIMIT_FULL),
        .o_valid(yaw_v), .o_angle(yaw)
    );

    assign m_axis_tvalid = roll_v;
    assign m_axis_tdata  = {1'b0, yaw, pitch[14:0], roll};

    // the three angle pipelines stay in lockstep
    a_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (roll_v == pitch_v) && (roll_v == yaw_v))
        else $error("angle pipelines out of step");

    // pitch never leaves the half-turn range
    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (pitch <= LIMIT_HALF) && (pitch >= -LIMIT_HALF))
        else $error("pitch out of range");

    // roll and yaw never leave the full-turn range
    a_full_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (roll <= LIMIT_FULL) && (roll >= -LIMIT_FULL)
                       && (yaw <= LIMIT_FULL) && (yaw >= -LIMIT_FULL))
        else $error("roll or yaw out of range");
endmodule

[dv/tb_quaternion_to_euler_angles.sv]
// tb_quaternion_to_euler_angles: self-checking bench for the quaternion to euler pipeline
// depends on qte_pkg and quaternion_to_euler_angles; predicts roll/pitch/yaw per quaternion
module tb_quaternion_to_euler_angles;
    import qte_pkg::*;

    localparam int ITERS       = NUM_ROT;
    localparam int LATENCY     = 50;
    localparam int N_RANDOM    = 1330;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } t_quat;

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } t_euler;

    // directed row: quaternion, and an expected angle set where it is obvious
    typedef struct {
        t_quat  q;
        bit     typed;
        t_euler e;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // quat_x, quat_y, quat_z, quat_w
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // roll_angle, pitch_angle, yaw_angle, pad

    t_euler angle_queue[$];
    int     errors = 0;
    int     cycles = 0;
    int     sent = 0;
    int     received = 0;
    int     phase = 0;         // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    bit     hold_off = 1'b0;   // long receiver hold-off

    quaternion_to_euler_angles DUT (.*);

    always #10 i_clk = ~i_clk;

    // timeout watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("quaternion_to_euler_angles: mismatch");
            $finish;
        end
    end

    // vectoring atan2 at scale 2^30, shifts floor toward minus infinity
    function automatic longint vector_angle(longint yv, longint xv);
        longint a, nx, ny, xs, ys;
        a = 0;
        if (xv == 0 && yv == 0) return 0;
        if (xv < 0) begin
            if (yv >= 0) begin
                nx = yv; ny = -xv; a = 2 * longint'(ATAN_TAB[0]);
            end else begin
                nx = -yv; ny = xv; a = -2 * longint'(ATAN_TAB[0]);
            end
            xv = nx; yv = ny;
        end
        for (int i = 0; i < ITERS; i++) begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0) begin
                nx = xv + ys; ny = yv - xs; a += ATAN_TAB[i];
            end else begin
                nx = xv - ys; ny = yv + xs; a -= ATAN_TAB[i];
            end
            xv = nx; yv = ny;
        end
        return a;
    endfunction

    // scale 2^30 to Q3.13, halves away from zero, then saturate
    function automatic longint round_angle(longint a, longint lim);
        longint m, r;
        m = (a < 0) ? -a : a;
        r = (m + 65536) >>> 17;
        if (r > lim) r = lim;
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned op, res, bitv;
        op = n; res = 0; bitv = 64'd1 << 62;
        while (bitv > op) bitv >>= 2;
        while (bitv != 0) begin
            if (op >= res + bitv) begin
                op -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic t_euler euler_of(t_quat q);
        longint x, y, z, w, s0, c0, sp, s1, c1, cp, one;
        t_euler e;
        one = 64'sd268435456;
        x = q.x; y = q.y; z = q.z; w = q.w;
        s0 = 2 * (w * x + y * z);
        c0 = one - 2 * (x * x + y * y);
        sp = 2 * (w * y - z * x);
        s1 = 2 * (w * z + x * y);
        c1 = one - 2 * (y * y + z * z);
        if (sp > one) sp = one;
        if (sp < -one) sp = -one;
        cp = floor_sqrt((64'd1 << 56) - longint'(sp * sp));
        e.roll  = 16'(round_angle(vector_angle(s0, c0), LIMIT_FULL));
        e.pitch = 15'(round_angle(vector_angle(sp, cp), LIMIT_HALF));
        e.yaw   = 16'(round_angle(vector_angle(s1, c1), LIMIT_FULL));
        return e;
    endfunction

    // input transfer: offer one quaternion, predict on acceptance
    task automatic send_quat(t_quat q, bit typed, t_euler e);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {q.w, q.z, q.y, q.x};
        do @(posedge i_clk); while (!s_axis_tready);
        angle_queue.push_back(typed ? e : euler_of(q));
        sent++;
        if ((phase == 1 || phase == 3) && $urandom_range(99) < 86) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    function automatic t_quat rand_quat();
        t_quat q;
        real a, b, c, d, n;
        int  k;
        k = $urandom_range(9);
        if (k < 6) begin
            // near unit quaternion, the normal case
            a = $itor($signed($urandom_range(65535) - 32768));
            b = $itor($signed($urandom_range(65535) - 32768));
            c = $itor($signed($urandom_range(65535) - 32768));
            d = $itor($signed($urandom_range(65535) - 32768));
            n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
            q.x = 16'($rtoi(a / n * 16384.0) + $signed($urandom_range(6)) - 3);
            q.y = 16'($rtoi(b / n * 16384.0) + $signed($urandom_range(6)) - 3);
            q.z = 16'($rtoi(c / n * 16384.0) + $signed($urandom_range(6)) - 3);
            q.w = 16'($rtoi(d / n * 16384.0) + $signed($urandom_range(6)) - 3);
        end else if (k < 8) begin
            q = t_quat'({$urandom, $urandom});
        end else begin
            // corners: components drawn from a few extreme values
            q.x = pick_corner(); q.y = pick_corner();
            q.z = pick_corner(); q.w = pick_corner();
        end
        return q;
    endfunction

    function automatic logic signed [15:0] pick_corner();
        case ($urandom_range(6))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sd16384;
            3: return -16'sd16384;
            4: return 16'sd11585;
            5: return -16'sd11585;
            default: return 16'sd0;
        endcase
    endfunction

    // output transfers, checked in order
    always @(posedge i_clk) begin
        t_euler got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.roll  = m_axis_tdata[15:0];
            got.pitch = m_axis_tdata[30:16];
            got.yaw   = m_axis_tdata[46:31];
            received++;
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                want = angle_queue.pop_front();
                if (got.roll !== want.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
                    errors++;
                end
                if (got.pitch !== want.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, want.pitch,
                             got.pitch);
                    errors++;
                end
                if (got.yaw !== want.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, want.yaw, got.yaw);
                    errors++;
                end
            end
        end
    end

    // receiver ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (hold_off)
            m_axis_tready <= 1'b0;
        else if (phase == 2 || phase == 3)
            m_axis_tready <= ($urandom_range(99) >= 86);
        else
            m_axis_tready <= 1'b1;
    end

    // long hold-off counted here, while the sender keeps offering
    initial begin
        wait (sent == 300);
        hold_off = 1'b1;
        repeat (150) @(posedge i_clk);
        hold_off = 1'b0;
    end

    t_row rows[$];

    function automatic t_row mk(int x, int y, int z, int w, bit typed = 0,
                                int r = 0, int p = 0, int yw = 0);
        t_row t;
        t.q = '{16'(x), 16'(y), 16'(z), 16'(w)};
        t.typed = typed;
        t.e = '{16'(r), 15'(p), 16'(yw)};
        return t;
    endfunction

    initial begin
        t_euler none;
        none = '0;
        // directed table
        rows.push_back(mk(0, 0, 0, 16384, 1, 0, 0, 0));        // identity
        rows.push_back(mk(0, 0, 0, 0));                        // zero quaternion
        rows.push_back(mk(16384, 0, 0, 0));                    // half turn about x
        rows.push_back(mk(0, 0, 16384, 0));                    // half turn about z
        rows.push_back(mk(0, 16384, 0, 0));
        rows.push_back(mk(0, 11585, 0, 11585));                // pitch at +pi/2
        rows.push_back(mk(0, -11585, 0, 11585));               // pitch at -pi/2
        rows.push_back(mk(0, 32767, 0, 32767));                // pitch clamped high
        rows.push_back(mk(0, -32768, 0, 32767));               // pitch clamped low
        rows.push_back(mk(32767, 32767, 32767, 32767));
        rows.push_back(mk(-32768, -32768, -32768, -32768));
        rows.push_back(mk(-32768, 32767, -32768, 32767));
        rows.push_back(mk(11585, 0, 0, 11585));
        rows.push_back(mk(-11585, 0, 0, 11585));
        rows.push_back(mk(0, 0, 11585, 11585));
        rows.push_back(mk(0, 0, -11585, 11585));
        rows.push_back(mk(8192, 8192, 8192, 8192));
        rows.push_back(mk(-1, -1, -1, -1));
        rows.push_back(mk(1, 0, 0, 0));
        rows.push_back(mk(0, 0, 1, -1));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_quat(rows[i].q, rows[i].typed, rows[i].e);

        for (int n = 0; n < N_RANDOM; n++) begin
            phase = (n / 80) % 4;
            if (n >= N_RANDOM - 100) phase = 0;
            send_quat(rand_quat(), 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);

        $display("%0d quaternions sent, %0d angle sets checked, %0d errors", sent,
                 received, errors);
        $display("covered identity, zero, clamped pitch, extremes and random idling/stalls");
        if (errors == 0 && angle_queue.size() == 0)
            $display("quaternion_to_euler_angles: match");
        else
            $display("quaternion_to_euler_angles: mismatch");
        $finish;
    end
endmodule

[files.f]
hw/rtl/qte_pkg.sv
hw/rtl/qte_prod.sv
hw/rtl/qte_isqrt.sv
hw/rtl/qte_cordic.sv
hw/rtl/quaternion_to_euler_angles.sv
dv/tb_quaternion_to_euler_angles.sv
